// ----- hdl/npm_pkg.sv -----
// ----------------------------------------------------------------------------
// npm_pkg
// Shared codes, register indexes, reset values and types of the noisy pixel
// mask finder.
// ----------------------------------------------------------------------------
package npm_pkg;

	// input word actions
	localparam logic [1:0] ACT_HIT     = 2'd0;
	localparam logic [1:0] ACT_EVENT   = 2'd1;
	localparam logic [1:0] ACT_PRELOAD = 2'd2;
	localparam logic [1:0] ACT_EVAL    = 2'd3;

	// configuration register map
	localparam int CFG_INDEX_W = 3;
	localparam int CFG_DATA_W  = 24;
	localparam logic [CFG_INDEX_W-1:0] CFG_MODE     = 3'd0;
	localparam logic [CFG_INDEX_W-1:0] CFG_FREQ_CUT = 3'd1;
	localparam logic [CFG_INDEX_W-1:0] CFG_BW_COL   = 3'd2;
	localparam logic [CFG_INDEX_W-1:0] CFG_BW_ROW   = 3'd3;
	localparam logic [CFG_INDEX_W-1:0] CFG_SIGMA    = 3'd4;
	localparam logic [CFG_INDEX_W-1:0] CFG_RATE     = 3'd5;

	localparam logic        RST_MODE     = 1'b0;
	localparam logic [23:0] RST_FREQ_CUT = 24'd12800;
	localparam logic [3:0]  RST_BW_COL   = 4'd2;
	localparam logic [3:0]  RST_BW_ROW   = 4'd2;
	localparam logic [15:0] RST_SIGMA    = 16'd1280;
	localparam logic [15:0] RST_RATE     = 16'd256;

	localparam int MEAN_W = 40;

	// request to the window walker
	typedef struct packed {
		logic       start;
		logic [3:0] bc;
		logic [3:0] br;
		logic [7:0] column;
		logic [7:0] row;
	} win_req_t;

endpackage

// ----- hdl/npm_ram.sv -----
// ----------------------------------------------------------------------------
// npm_ram
// Generic RAM with one write port and one registered read port.
// ----------------------------------------------------------------------------
module npm_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

// ----- hdl/npm_mul.sv -----
// ----------------------------------------------------------------------------
// npm_mul
// Shift-add multiplier, one bit of operand b per cycle, product modulo 2^A_W.
// ----------------------------------------------------------------------------
module npm_mul #(
	parameter int A_W = 64,
	parameter int B_W = 32
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	input  logic [A_W-1:0] a,
	input  logic [B_W-1:0] b,
	output logic           busy,
	output logic [A_W-1:0] product
);

	localparam int CW = $clog2(B_W + 1);

	logic           busy_q;
	logic [CW-1:0]  cnt_q;
	logic [A_W-1:0] acc_q;
	logic [A_W-1:0] a_q;
	logic [B_W-1:0] b_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= CW'(B_W);
		end else if (busy_q) begin
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == CW'(1)) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			acc_q <= '0;
			a_q   <= a;
			b_q   <= b;
		end else if (busy_q) begin
			if (b_q[0]) begin
				acc_q <= acc_q + a_q;
			end
			a_q <= a_q << 1;
			b_q <= b_q >> 1;
		end
	end

	assign busy    = busy_q;
	assign product = acc_q;

endmodule

// ----- hdl/npm_div.sv -----
// ----------------------------------------------------------------------------
// npm_div
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module npm_div #(
	parameter int N_W = 64,
	parameter int D_W = 32
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	input  logic [N_W-1:0] num,
	input  logic [D_W-1:0] den,
	output logic           busy,
	output logic [N_W-1:0] quotient
);

	localparam int CW = $clog2(N_W + 1);

	logic           busy_q;
	logic [CW-1:0]  cnt_q;
	logic [N_W-1:0] num_q;
	logic [N_W-1:0] quo_q;
	logic [D_W-1:0] den_q;
	logic [D_W-1:0] rem_q;
	logic [D_W:0]   rem_sh;
	logic [D_W:0]   rem_sub;
	logic           fits;

	assign rem_sh  = {rem_q, num_q[N_W-1]};
	assign rem_sub = rem_sh - {1'b0, den_q};
	assign fits    = rem_sh >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= CW'(N_W);
		end else if (busy_q) begin
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == CW'(1)) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= num;
			den_q <= den;
			rem_q <= '0;
			quo_q <= '0;
		end else if (busy_q) begin
			num_q <= num_q << 1;
			quo_q <= {quo_q[N_W-2:0], fits};
			rem_q <= fits ? rem_sub[D_W-1:0] : rem_sh[D_W-1:0];
		end
	end

	assign busy     = busy_q;
	assign quotient = quo_q;

endmodule

// ----- hdl/npm_window.sv -----
// ----------------------------------------------------------------------------
// npm_window
// Walks the elliptic kernel window around one pixel, reads the neighbour
// counts from the pixel memory and accumulates weight and weighted counts.
// ----------------------------------------------------------------------------
module npm_window import npm_pkg::*; #(
	parameter int COLUMNS    = 256,
	parameter int ROWS       = 256,
	parameter int COUNT_BITS = 32,
	parameter int WT_W       = 16,
	parameter int W_W        = 26,
	parameter int S_W        = 58
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  win_req_t                         req,
	output logic [$clog2(COLUMNS*ROWS)-1:0]  raddr,
	input  logic [COUNT_BITS-1:0]            rdata_count,
	output logic                             busy,
	output logic [S_W-1:0]                   s_sum,
	output logic [W_W-1:0]                   w_sum
);

	localparam int AW  = $clog2(COLUMNS * ROWS);
	localparam int PRW = WT_W + COUNT_BITS;

	logic              walk_q;
	logic signed [4:0] dc_q, dr_q;
	logic [3:0]        bc_q, br_q;
	logic [7:0]        col_q, row_q;
	logic [7:0]        bc2_q, br2_q;
	logic [WT_W-1:0]   full_q;

	logic [3:0]        dc_abs, dr_abs;
	logic signed [9:0] c_w, r_w;
	logic              ok_w;

	logic              live_s1, ok_s1;
	logic [7:0]        dc2_s1, dr2_s1;
	logic [8:0]        c_s1, r_s1;
	logic              live_s2, ok_s2;
	logic [WT_W-1:0]   a_s2, b_s2;
	logic [AW-1:0]     addr_s2;
	logic [31:0]       addr_w;
	logic signed [WT_W+1:0] wt_w;
	logic              valid_s3, valid_s4, valid_s5;
	logic [WT_W-1:0]   w_s3, w_s4, w_s5;
	logic [AW-1:0]     addr_s3;
	logic [PRW-1:0]    prod_s5;
	logic [S_W-1:0]    s_q;
	logic [W_W-1:0]    w_q;

	assign dc_abs = dc_q[4] ? 4'(-dc_q) : dc_q[3:0];
	assign dr_abs = dr_q[4] ? 4'(-dr_q) : dr_q[3:0];
	assign c_w    = $signed({2'b00, col_q}) + $signed({{5{dc_q[4]}}, dc_q});
	assign r_w    = $signed({2'b00, row_q}) + $signed({{5{dr_q[4]}}, dr_q});
	assign ok_w   = !c_w[9] && (32'(c_w[8:0]) < COLUMNS) && !r_w[9] &&
		(32'(r_w[8:0]) < ROWS) && !(dc_q == 5'sd0 && dr_q == 5'sd0);
	assign addr_w = 32'(c_s1) * ROWS + 32'(r_s1);
	assign wt_w   = $signed({2'b00, full_q}) - $signed({2'b00, a_s2}) -
		$signed({2'b00, b_s2});

	// window walk, rows fastest
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			walk_q <= 1'b0;
			dc_q   <= '0;
			dr_q   <= '0;
			bc_q   <= '0;
			br_q   <= '0;
			col_q  <= '0;
			row_q  <= '0;
		end else if (req.start) begin
			walk_q <= 1'b1;
			dc_q   <= -$signed({1'b0, req.bc});
			dr_q   <= -$signed({1'b0, req.br});
			bc_q   <= req.bc;
			br_q   <= req.br;
			col_q  <= req.column;
			row_q  <= req.row;
		end else if (walk_q) begin
			if (dr_q == $signed({1'b0, br_q})) begin
				dr_q <= -$signed({1'b0, br_q});
				if (dc_q == $signed({1'b0, bc_q})) begin
					walk_q <= 1'b0;
				end else begin
					dc_q <= dc_q + 5'sd1;
				end
			end else begin
				dr_q <= dr_q + 5'sd1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			live_s1  <= 1'b0;
			live_s2  <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
		end else begin
			live_s1  <= walk_q;
			live_s2  <= live_s1;
			valid_s3 <= live_s2 && ok_s2 && (wt_w > 0);
			valid_s4 <= valid_s3;
			valid_s5 <= valid_s4;
		end
	end

	always_ff @(posedge clk) begin
		bc2_q   <= 8'(bc_q * bc_q);
		br2_q   <= 8'(br_q * br_q);
		full_q  <= WT_W'(bc2_q * br2_q);
		ok_s1   <= ok_w;
		dc2_s1  <= 8'(dc_abs * dc_abs);
		dr2_s1  <= 8'(dr_abs * dr_abs);
		c_s1    <= c_w[8:0];
		r_s1    <= r_w[8:0];
		ok_s2   <= ok_s1;
		a_s2    <= WT_W'(dc2_s1 * br2_q);
		b_s2    <= WT_W'(dr2_s1 * bc2_q);
		addr_s2 <= ok_s1 ? addr_w[AW-1:0] : '0;
		w_s3    <= wt_w[WT_W-1:0];
		addr_s3 <= addr_s2;
		w_s4    <= w_s3;
		w_s5    <= w_s4;
		prod_s5 <= PRW'(w_s4) * PRW'(rdata_count);
		if (req.start) begin
			s_q <= '0;
			w_q <= '0;
		end else if (valid_s5) begin
			s_q <= s_q + S_W'(prod_s5);
			w_q <= w_q + W_W'(w_s5);
		end
	end

	assign raddr = addr_s3;
	assign busy  = walk_q | live_s1 | live_s2 | valid_s3 | valid_s4 | valid_s5;
	assign s_sum = s_q;
	assign w_sum = w_q;

endmodule

// ----- hdl/noisy_pixel_mask_finder_unit.sv -----
// ----------------------------------------------------------------------------
// noisy_pixel_mask_finder_unit
// Per-pixel hit counter with prior mask bits and a noisy pixel test by
// global frequency or by local kernel density.
// ----------------------------------------------------------------------------
//  channel  | signals                                         | dir
//  ---------+-------------------------------------------------+-----
//  config   | cfg_we, cfg_index, cfg_data                     | in
//  input    | in_valid, in_ready, action, column, row         | in
//  result   | out_valid, out_ready, column_out, row_out,      | out
//           | noisy, hit_count, neighbour_mean_q8             |
//
// After reset the pixel memory is cleared word by word, with in_ready low.
// Hit and preload go through a memory read, then a write back; end of event only counts the event.
// Frequency evaluation: two serial multiplies between accept and next accept.
// Density evaluation: window walk on the memory read port, then up to four
// serial multiplies, with the divider overlapping them.
// A waiting result does not stop hits: only the next result waits for out_ready.
module noisy_pixel_mask_finder_unit import npm_pkg::*; #(
	parameter int COLUMNS       = 256,
	parameter int ROWS          = 256,
	parameter int COUNT_BITS    = 32,
	parameter int MAX_BANDWIDTH = 15
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_we,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_data,
	input  logic                   in_valid,
	output logic                   in_ready,
	input  logic [1:0]             action,
	input  logic [7:0]             column,
	input  logic [7:0]             row,
	output logic                   out_valid,
	input  logic                   out_ready,
	output logic [7:0]             column_out,
	output logic [7:0]             row_out,
	output logic                   noisy,
	output logic [31:0]            hit_count,
	output logic [MEAN_W-1:0]      neighbour_mean_q8
);

	localparam int EMB   = MAX_BANDWIDTH < 15 ? MAX_BANDWIDTH : 15;
	localparam int WT_W  = $clog2(EMB * EMB * EMB * EMB + 1);
	localparam int WIN_W = $clog2((2 * EMB + 1) * (2 * EMB + 1));
	localparam int W_W   = WT_W + WIN_W;
	localparam int S_W   = COUNT_BITS + W_W;
	localparam int PW    = 2 * S_W + 48;
	localparam int BW    = S_W > 48 ? S_W : 48;
	localparam int N_W   = S_W + 8;
	localparam int QW    = N_W > MEAN_W ? N_W : MEAN_W;
	localparam int RTW   = COUNT_BITS + 8 > 48 ? COUNT_BITS + 8 : 48;
	localparam int HW    = COUNT_BITS > 32 ? COUNT_BITS : 32;
	localparam int DEPTH = COLUMNS * ROWS;
	localparam int AW    = $clog2(DEPTH);
	localparam longint unsigned PIX256 = longint'(COLUMNS) * longint'(ROWS) * 256;
	localparam logic [3:0] EMB4 = 4'(EMB);

	localparam logic [3:0] ST_CLEAR  = 4'd0;
	localparam logic [3:0] ST_IDLE   = 4'd1;
	localparam logic [3:0] ST_RMW    = 4'd2;
	localparam logic [3:0] ST_EVREAD = 4'd3;
	localparam logic [3:0] ST_FQ1    = 4'd4;
	localparam logic [3:0] ST_FQ2    = 4'd5;
	localparam logic [3:0] ST_WIN    = 4'd6;
	localparam logic [3:0] ST_VW     = 4'd7;
	localparam logic [3:0] ST_DD     = 4'd8;
	localparam logic [3:0] ST_SS     = 4'd9;
	localparam logic [3:0] ST_SW     = 4'd10;
	localparam logic [3:0] ST_DIV    = 4'd11;
	localparam logic [3:0] ST_DONE   = 4'd12;

	// configuration
	logic        mode_q;
	logic [23:0] cut_q;
	logic [3:0]  bwc_q, bwr_q;
	logic [15:0] sigma_q, rate_q;

	logic [3:0]  state_q;
	logic [AW-1:0] clr_q;
	logic [47:0] total_q;
	logic [31:0] event_q;

	logic [1:0]  act_q;
	logic [7:0]  col_q, row_q;
	logic        inside_q;
	logic [AW-1:0] idx_q;
	logic [COUNT_BITS-1:0] v_q;
	logic        m_q;
	logic [PW-1:0] lhs_q;
	logic [47:0] rt_q;
	logic        rel_q;
	logic        res_noisy_q;
	logic [MEAN_W-1:0] res_mean_q;

	logic        out_valid_q;
	logic [7:0]  col_out_q, row_out_q;
	logic        noisy_q;
	logic [31:0] hit_q;
	logic [MEAN_W-1:0] mean_q;

	logic        acc;
	logic        in_inside;
	logic [31:0] in_lin;
	logic [AW-1:0] in_idx;

	logic        ram_we;
	logic [AW-1:0] ram_waddr, ram_raddr, win_raddr;
	logic [COUNT_BITS:0] ram_wdata, ram_rdata;
	logic [COUNT_BITS-1:0] rd_count;
	logic        rd_mask;

	logic        mul_start, mul_busy;
	logic [PW-1:0] mul_a, mul_prod;
	logic [BW-1:0] mul_b;
	logic        div_start, div_busy;
	logic [N_W-1:0] div_quo;
	logic [QW-1:0] quo_x;
	logic [MEAN_W-1:0] mean_sat;

	win_req_t    win_req;
	logic        win_busy;
	logic [S_W-1:0] s_sum;
	logic [W_W-1:0] w_sum;

	logic [31:0] sigma2;
	logic [PW-1:0] d_w;
	logic        rate_hit;
	logic [HW-1:0] v_x;

	assign acc       = in_valid && in_ready;
	assign in_ready  = state_q == ST_IDLE;
	assign in_inside = (32'(column) < COLUMNS) && (32'(row) < ROWS);
	assign in_lin    = 32'(column) * ROWS + 32'(row);
	assign in_idx    = in_inside ? in_lin[AW-1:0] : '0;

	assign rd_count  = ram_rdata[COUNT_BITS-1:0];
	assign rd_mask   = ram_rdata[COUNT_BITS];
	assign ram_raddr = (state_q == ST_WIN) ? win_raddr : in_idx;

	assign sigma2    = 32'(sigma_q) * 32'(sigma_q);
	assign d_w       = mul_prod - PW'(s_sum);
	assign rate_hit  = RTW'({v_q, 8'h00}) > RTW'(rt_q);
	assign quo_x     = QW'(div_quo);
	assign mean_sat  = (quo_x > QW'({MEAN_W{1'b1}})) ? {MEAN_W{1'b1}} : quo_x[MEAN_W-1:0];
	assign v_x       = HW'(v_q);

	assign win_req.start  = (state_q == ST_EVREAD) && inside_q && mode_q;
	assign win_req.bc     = (bwc_q > EMB4) ? EMB4 : bwc_q;
	assign win_req.br     = (bwr_q > EMB4) ? EMB4 : bwr_q;
	assign win_req.column = col_q;
	assign win_req.row    = row_q;

	assign div_start = (state_q == ST_WIN) && !win_busy && (w_sum != '0);

	// memory write port: clearing pass or read-modify-write
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = idx_q;
		ram_wdata = ram_rdata;
		unique case (state_q)
			ST_CLEAR: begin
				ram_we    = 1'b1;
				ram_waddr = clr_q;
				ram_wdata = '0;
			end
			ST_RMW: begin
				ram_we = 1'b1;
				if (act_q == ACT_HIT) begin
					ram_wdata = {rd_mask, (&rd_count) ? rd_count : rd_count + 1'b1};
				end else begin
					ram_wdata = {1'b1, rd_count};
				end
			end
			default: begin
				ram_we = 1'b0;
			end
		endcase
	end

	// serial multiplier operand selection
	always_comb begin
		mul_start = 1'b0;
		mul_a     = '0;
		mul_b     = '0;
		unique case (state_q)
			ST_EVREAD: begin
				mul_start = inside_q && !mode_q;
				mul_a     = PW'(PIX256);
				mul_b     = BW'(rd_count);
			end
			ST_FQ1: begin
				mul_start = !mul_busy;
				mul_a     = PW'(total_q);
				mul_b     = BW'(cut_q);
			end
			ST_WIN: begin
				mul_start = !win_busy && (w_sum != '0);
				mul_a     = PW'(w_sum);
				mul_b     = BW'(v_q);
			end
			ST_VW: begin
				mul_start = !mul_busy && (mul_prod > PW'(s_sum));
				mul_a     = d_w;
				mul_b     = BW'(d_w);
			end
			ST_DD: begin
				mul_start = !mul_busy;
				mul_a     = PW'(s_sum);
				mul_b     = BW'(sigma2);
			end
			ST_SS: begin
				mul_start = !mul_busy;
				mul_a     = mul_prod;
				mul_b     = BW'(w_sum);
			end
			default: begin
				mul_start = 1'b0;
			end
		endcase
	end

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= RST_MODE;
			cut_q   <= RST_FREQ_CUT;
			bwc_q   <= RST_BW_COL;
			bwr_q   <= RST_BW_ROW;
			sigma_q <= RST_SIGMA;
			rate_q  <= RST_RATE;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_MODE:     mode_q  <= cfg_data[0];
				CFG_FREQ_CUT: cut_q   <= cfg_data[23:0];
				CFG_BW_COL:   bwc_q   <= cfg_data[3:0];
				CFG_BW_ROW:   bwr_q   <= cfg_data[3:0];
				CFG_SIGMA:    sigma_q <= cfg_data[15:0];
				CFG_RATE:     rate_q  <= cfg_data[15:0];
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			clr_q       <= '0;
			total_q     <= '0;
			event_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && out_ready && state_q != ST_DONE) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == AW'(DEPTH - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (acc) begin
						if (action == ACT_EVENT) begin
							if (!(&event_q)) begin
								event_q <= event_q + 1'b1;
							end
						end else if (action == ACT_EVAL) begin
							state_q <= ST_EVREAD;
						end else if (in_inside) begin
							state_q <= ST_RMW;
						end
					end
				end
				ST_RMW: begin
					if (act_q == ACT_HIT && !(&total_q)) begin
						total_q <= total_q + 1'b1;
					end
					state_q <= ST_IDLE;
				end
				ST_EVREAD: begin
					if (!inside_q) begin
						state_q <= ST_DONE;
					end else if (mode_q) begin
						state_q <= ST_WIN;
					end else begin
						state_q <= ST_FQ1;
					end
				end
				ST_FQ1: begin
					if (!mul_busy) begin
						state_q <= ST_FQ2;
					end
				end
				ST_FQ2: begin
					if (!mul_busy) begin
						state_q <= ST_DONE;
					end
				end
				ST_WIN: begin
					if (!win_busy) begin
						state_q <= (w_sum == '0) ? ST_DONE : ST_VW;
					end
				end
				ST_VW: begin
					if (!mul_busy) begin
						state_q <= (mul_prod > PW'(s_sum)) ? ST_DD : ST_DIV;
					end
				end
				ST_DD: begin
					if (!mul_busy) begin
						state_q <= ST_SS;
					end
				end
				ST_SS: begin
					if (!mul_busy) begin
						state_q <= ST_SW;
					end
				end
				ST_SW: begin
					if (!mul_busy) begin
						state_q <= ST_DIV;
					end
				end
				ST_DIV: begin
					if (!div_busy) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (!out_valid_q || out_ready) begin
						out_valid_q <= 1'b1;
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// item and result payload
	always_ff @(posedge clk) begin
		if (acc) begin
			act_q    <= action;
			col_q    <= column;
			row_q    <= row;
			inside_q <= in_inside;
			idx_q    <= in_idx;
		end
		case (state_q)
			ST_EVREAD: begin
				v_q         <= inside_q ? rd_count : '0;
				m_q         <= rd_mask;
				rt_q        <= 48'(rate_q) * 48'(event_q);
				rel_q       <= 1'b0;
				res_noisy_q <= 1'b0;
				res_mean_q  <= '0;
			end
			ST_FQ1: begin
				if (!mul_busy) begin
					lhs_q <= mul_prod;
				end
			end
			ST_FQ2: begin
				if (!mul_busy) begin
					res_noisy_q <= m_q || (lhs_q > mul_prod);
				end
			end
			ST_WIN: begin
				if (!win_busy && w_sum == '0) begin
					res_noisy_q <= rate_hit;
				end
			end
			ST_DD: begin
				if (!mul_busy) begin
					lhs_q <= mul_prod << 16;
				end
			end
			ST_SW: begin
				if (!mul_busy) begin
					rel_q <= lhs_q > mul_prod;
				end
			end
			ST_DIV: begin
				if (!div_busy) begin
					res_mean_q  <= mean_sat;
					res_noisy_q <= rel_q || rate_hit;
				end
			end
			ST_DONE: begin
				if (!out_valid_q || out_ready) begin
					col_out_q <= col_q;
					row_out_q <= row_q;
					noisy_q   <= res_noisy_q;
					hit_q     <= (v_x > HW'(32'hFFFF_FFFF)) ? 32'hFFFF_FFFF : v_x[31:0];
					mean_q    <= res_mean_q;
				end
			end
			default: begin
			end
		endcase
	end

	npm_ram #(
		.WIDTH(COUNT_BITS + 1),
		.DEPTH(DEPTH)
	) u_pixel_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	npm_window #(
		.COLUMNS   (COLUMNS),
		.ROWS      (ROWS),
		.COUNT_BITS(COUNT_BITS),
		.WT_W      (WT_W),
		.W_W       (W_W),
		.S_W       (S_W)
	) u_window (
		.clk        (clk),
		.arst_n     (arst_n),
		.req        (win_req),
		.raddr      (win_raddr),
		.rdata_count(rd_count),
		.busy       (win_busy),
		.s_sum      (s_sum),
		.w_sum      (w_sum)
	);

	npm_mul #(
		.A_W(PW),
		.B_W(BW)
	) u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (mul_start),
		.a      (mul_a),
		.b      (mul_b),
		.busy   (mul_busy),
		.product(mul_prod)
	);

	npm_div #(
		.N_W(N_W),
		.D_W(W_W)
	) u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (div_start),
		.num     ({s_sum, 8'h00}),
		.den     (w_sum),
		.busy    (div_busy),
		.quotient(div_quo)
	);

	assign out_valid         = out_valid_q;
	assign column_out        = col_out_q;
	assign row_out           = row_out_q;
	assign noisy             = noisy_q;
	assign hit_count         = hit_q;
	assign neighbour_mean_q8 = mean_q;

	// an accepted hit inside the matrix writes back on the next cycle
	a_hit_writeback: assert property (@(posedge clk) disable iff (!arst_n)
		(acc && action == ACT_HIT && in_inside) |=> ram_we)
		else $error("hit word not written back");

	a_mul_idle: assert property (@(posedge clk) disable iff (!arst_n)
		mul_start |-> !mul_busy)
		else $error("multiplier started while busy");

	a_result_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q) == ST_DONE)
		else $error("result word without finished evaluation");

	a_total_monotonic: assert property (@(posedge clk) disable iff (!arst_n)
		1'b1 |=> total_q >= $past(total_q))
		else $error("total hit count decreased");

endmodule
